@@ rtl/max_pool_argmax_unpool_defines.svh @@
`ifndef MAX_POOL_ARGMAX_UNPOOL_DEFINES_SVH
`define MAX_POOL_ARGMAX_UNPOOL_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MPAU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MPAU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/mpau_pkg.sv @@
`default_nettype none

package mpau_pkg;

	localparam int VW       = 16;
	localparam int OFF_W    = 3;
	localparam int POS_W    = 12;
	localparam int CNT_W    = 13;
	localparam int MAX_POOL = 8;

	localparam logic [VW-1:0] ONE_Q = 16'h0100;

	localparam logic KIND_POOL = 1'b0;
	localparam logic KIND_GRAD = 1'b1;

	typedef enum logic [1:0] {
		FUNC_FWD  = 2'd0,
		FUNC_LOAD = 2'd1,
		FUNC_BWD  = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		REG_POOL_H = 3'd0,
		REG_POOL_W = 3'd1,
		REG_IN_W   = 3'd2,
		REG_IN_H   = 3'd3,
		REG_OUT_W  = 3'd4,
		REG_OUT_H  = 3'd5
	} reg_idx_t;

	// clamped configuration
	typedef struct packed {
		logic [3:0]       ph;
		logic [3:0]       pw;
		logic [CNT_W-1:0] iw;
		logic [CNT_W-1:0] ih;
		logic [CNT_W-1:0] ow;
		logic [CNT_W-1:0] oh;
	} cfg_t;

	// window position of the current pixel
	typedef struct packed {
		logic [POS_W-1:0] wr;
		logic [OFF_W-1:0] rr;
		logic [POS_W-1:0] wc;
		logic [OFF_W-1:0] cc;
		logic             covered;
		logic             first;
		logic             last;
	} pos_t;

	typedef struct packed {
		logic [VW-1:0]    peak;
		logic [OFF_W-1:0] row;
		logic [OFF_W-1:0] col;
	} ls_entry_t;

endpackage

`default_nettype wire

@@ rtl/mpau_pos.sv @@
`default_nettype none

module mpau_pos
	import mpau_pkg::*;
(
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  cfg_t cfg,
	input  wire  logic cfg_we,
	input  wire  logic step,
	output pos_t       pos,
	output logic       busy
);

	localparam logic [3:0] LAST_STEP = 4'(POS_W - 1);

	logic [POS_W-1:0] row_q, col_q, wr_q, wc_q;
	logic [OFF_W-1:0] rr_q, cc_q;
	logic             busy_q;
	logic [3:0]       cnt_q;
	logic [POS_W-1:0] rdiv_q, cdiv_q, rquo_q, cquo_q;
	logic [OFF_W-1:0] rrem_q, crem_q;

	logic             col_wrap, row_wrap, cc_last, rr_last;
	logic [3:0]       rsh, csh;
	logic             rbit, cbit;
	logic [OFF_W-1:0] rrem_d, crem_d;

	always_comb begin
		col_wrap = (CNT_W'(col_q) + CNT_W'(1)) >= cfg.iw;
		row_wrap = (CNT_W'(row_q) + CNT_W'(1)) >= cfg.ih;
		cc_last  = {1'b0, cc_q} == (cfg.pw - 4'd1);
		rr_last  = {1'b0, rr_q} == (cfg.ph - 4'd1);

		pos.wr      = wr_q;
		pos.rr      = rr_q;
		pos.wc      = wc_q;
		pos.cc      = cc_q;
		pos.covered = (CNT_W'(wc_q) < cfg.ow) && (CNT_W'(wr_q) < cfg.oh);
		pos.first   = (rr_q == '0) && (cc_q == '0);
		pos.last    = rr_last && cc_last;

		// one restoring step on each of row / pool_height and col / pool_width
		rsh    = {rrem_q, rdiv_q[POS_W-1]};
		csh    = {crem_q, cdiv_q[POS_W-1]};
		rbit   = rsh >= cfg.ph;
		cbit   = csh >= cfg.pw;
		rrem_d = rbit ? OFF_W'(rsh - cfg.ph) : OFF_W'(rsh);
		crem_d = cbit ? OFF_W'(csh - cfg.pw) : OFF_W'(csh);
	end

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			wr_q   <= '0;
			wc_q   <= '0;
			rr_q   <= '0;
			cc_q   <= '0;
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rdiv_q <= '0;
			cdiv_q <= '0;
			rquo_q <= '0;
			cquo_q <= '0;
			rrem_q <= '0;
			crem_q <= '0;
		end else if (cfg_we) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			rdiv_q <= row_q;
			cdiv_q <= col_q;
			rrem_q <= '0;
			crem_q <= '0;
		end else if (busy_q) begin
			rdiv_q <= {rdiv_q[POS_W-2:0], 1'b0};
			cdiv_q <= {cdiv_q[POS_W-2:0], 1'b0};
			rquo_q <= {rquo_q[POS_W-2:0], rbit};
			cquo_q <= {cquo_q[POS_W-2:0], cbit};
			rrem_q <= rrem_d;
			crem_q <= crem_d;
			cnt_q  <= cnt_q + 4'd1;
			if (cnt_q == LAST_STEP) begin
				busy_q <= 1'b0;
				wr_q   <= {rquo_q[POS_W-2:0], rbit};
				wc_q   <= {cquo_q[POS_W-2:0], cbit};
				rr_q   <= rrem_d;
				cc_q   <= crem_d;
			end
		end else if (step) begin
			if (col_wrap) begin
				col_q <= '0;
				wc_q  <= '0;
				cc_q  <= '0;
				if (row_wrap) begin
					row_q <= '0;
					wr_q  <= '0;
					rr_q  <= '0;
				end else begin
					row_q <= row_q + POS_W'(1);
					if (rr_last) begin
						rr_q <= '0;
						wr_q <= wr_q + POS_W'(1);
					end else begin
						rr_q <= rr_q + OFF_W'(1);
					end
				end
			end else begin
				col_q <= col_q + POS_W'(1);
				if (cc_last) begin
					cc_q <= '0;
					wc_q <= wc_q + POS_W'(1);
				end else begin
					cc_q <= cc_q + OFF_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/mpau_core.sv @@
`default_nettype none

module mpau_core
	import mpau_pkg::*;
#(
	parameter int MAX_OUT_COLS = 256
) (
	input  wire  logic                 clk,
	input  wire  logic                 arst_n,
	input  wire  cfg_t                 cfg,
	input  wire  logic                 accept,
	input  wire  logic [1:0]           func,
	input  wire  logic signed [VW-1:0] value,
	input  wire  pos_t                 pos,
	output logic                       hold,
	output logic                       out_valid,
	input  wire  logic                 out_stall,
	output logic                       result_kind,
	output logic signed [VW-1:0]       out_value,
	output logic [OFF_W-1:0]           arg_row,
	output logic [OFF_W-1:0]           arg_col,
	output logic [POS_W-1:0]           pooled_row,
	output logic [7:0]                 pooled_col
);

	localparam int AW    = (MAX_OUT_COLS > 1) ? $clog2(MAX_OUT_COLS) : 1;
	localparam int DEPTH = MAX_OUT_COLS;

	ls_entry_t     line_mem [DEPTH];
	logic [VW-1:0] err_mem  [DEPTH];

	logic [AW-1:0] rd_addr, lp_q, lp_eff, lp_next;
	logic          is_pixel, ls_we, eb_we, emit_s1, go_s1, take;
	ls_entry_t     cur, ls_new;
	logic [VW-1:0] grad;

	logic          valid_s1, fwd_hit_s1;
	logic [1:0]    func_s1;
	logic [VW-1:0] val_s1;
	pos_t          pos_s1;
	ls_entry_t     ls_rd_s1, fwd_data_s1;
	logic [VW-1:0] eb_rd_s1;

	logic          out_valid_q, kind_q;
	logic [VW-1:0] value_q;
	logic [OFF_W-1:0] arow_q, acol_q;
	logic [POS_W-1:0] prow_q;
	logic [7:0]    pcol_q;

	always_comb begin
		rd_addr  = pos.wc[AW-1:0];
		is_pixel = (func == FUNC_FWD) || (func == FUNC_BWD);
		eb_we    = accept && (func == FUNC_LOAD);
		lp_eff   = (CNT_W'(lp_q) >= cfg.ow) ? '0 : lp_q;
		lp_next  = ((CNT_W'(lp_eff) + CNT_W'(1)) >= cfg.ow) ? '0 : AW'(lp_eff + 1'b1);

		emit_s1 = ((func_s1 == FUNC_FWD) && pos_s1.covered && pos_s1.last) ||
		          (func_s1 == FUNC_BWD);
		hold    = valid_s1 && emit_s1 && out_valid_q && out_stall;
		go_s1   = valid_s1 && !hold;
		ls_we   = go_s1 && (func_s1 == FUNC_FWD) && pos_s1.covered;

		// the write of the preceding beat lands at this beat's read edge
		cur    = fwd_hit_s1 ? fwd_data_s1 : ls_rd_s1;
		take   = pos_s1.first || ($signed(val_s1) > $signed(cur.peak));
		ls_new = take ? ls_entry_t'{peak: val_s1, row: pos_s1.rr, col: pos_s1.cc} : cur;
		grad   = (pos_s1.covered && (val_s1 == ONE_Q)) ? eb_rd_s1 : val_s1;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ls_rd_s1    <= line_mem[rd_addr];
			eb_rd_s1    <= err_mem[rd_addr];
			func_s1     <= func;
			val_s1      <= value;
			pos_s1      <= pos;
			fwd_data_s1 <= ls_new;
		end
		if (ls_we)
			line_mem[pos_s1.wc[AW-1:0]] <= ls_new;
		if (eb_we)
			err_mem[lp_eff] <= value;
		if (go_s1 && emit_s1) begin
			if (func_s1 == FUNC_FWD) begin
				kind_q  <= KIND_POOL;
				value_q <= ls_new.peak;
				arow_q  <= ls_new.row;
				acol_q  <= ls_new.col;
				prow_q  <= pos_s1.wr;
				pcol_q  <= pos_s1.wc[7:0];
			end else begin
				kind_q  <= KIND_GRAD;
				value_q <= grad;
				arow_q  <= '0;
				acol_q  <= '0;
				prow_q  <= '0;
				pcol_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_hit_s1  <= 1'b0;
			lp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!hold)
				valid_s1 <= accept && is_pixel;
			if (accept)
				fwd_hit_s1 <= ls_we && (pos_s1.wc[AW-1:0] == rd_addr);
			if (eb_we)
				lp_q <= lp_next;
			if (go_s1 && emit_s1)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign out_value   = value_q;
	assign arg_row     = arow_q;
	assign arg_col     = acol_q;
	assign pooled_row  = prow_q;
	assign pooled_col  = pcol_q;

endmodule

`default_nettype wire

@@ rtl/max_pool_argmax_unpool.sv @@
// A taken beat is registered in the s1 stage, then its result in the output register.
// Throughput: one beat per cycle unless a rebuild or a stalled output holds input; the
// line store is read at acceptance and written back from the s1 stage, with the
// preceding beat's write forwarded. Any configuration write stalls input while the
// window position is re-derived by a bit-serial divide. Reset: registers to defaults,
// positions zero; line store and error band are undefined until written, not cleared.
`default_nettype none

module max_pool_argmax_unpool
	import mpau_pkg::*;
#(
	parameter int MAX_OUT_COLS = 256
) (
	input  wire  logic                 clk,
	input  wire  logic                 arst_n,
	input  wire  logic                 cfg_we,
	input  wire  logic [2:0]           cfg_index,
	input  wire  logic [CNT_W-1:0]     cfg_data,
	input  wire  logic                 in_valid,
	output logic                       in_stall,
	input  wire  logic [1:0]           func,
	input  wire  logic signed [VW-1:0] value,
	output logic                       out_valid,
	input  wire  logic                 out_stall,
	output logic                       result_kind,
	output logic signed [VW-1:0]       out_value,
	output logic [OFF_W-1:0]           arg_row,
	output logic [OFF_W-1:0]           arg_col,
	output logic [POS_W-1:0]           pooled_row,
	output logic [7:0]                 pooled_col
);

	localparam logic [CNT_W-1:0] MAX_DIM = 13'd4096;
	localparam logic [CNT_W-1:0] MAX_OW  = CNT_W'(MAX_OUT_COLS);

	logic [3:0]       pool_h_q, pool_w_q;
	logic [CNT_W-1:0] in_w_q, in_h_q, out_h_q;
	logic [8:0]       out_w_q;

	cfg_t cfg;
	pos_t pos;
	logic busy, hold, accept, step;

	always_comb begin
		cfg.ph = (pool_h_q == '0) ? 4'd1 : ((pool_h_q > 4'(MAX_POOL)) ? 4'(MAX_POOL) : pool_h_q);
		cfg.pw = (pool_w_q == '0) ? 4'd1 : ((pool_w_q > 4'(MAX_POOL)) ? 4'(MAX_POOL) : pool_w_q);
		cfg.iw = (in_w_q == '0) ? CNT_W'(1) : ((in_w_q > MAX_DIM) ? MAX_DIM : in_w_q);
		cfg.ih = (in_h_q == '0) ? CNT_W'(1) : ((in_h_q > MAX_DIM) ? MAX_DIM : in_h_q);
		cfg.ow = (out_w_q == '0) ? CNT_W'(1) :
		         ((CNT_W'(out_w_q) > MAX_OW) ? MAX_OW : CNT_W'(out_w_q));
		cfg.oh = (out_h_q == '0) ? CNT_W'(1) : ((out_h_q > MAX_DIM) ? MAX_DIM : out_h_q);
	end

	assign in_stall = busy || hold;
	assign accept   = in_valid && !in_stall;
	assign step     = accept && ((func == FUNC_FWD) || (func == FUNC_BWD));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_h_q <= 4'd2;
			pool_w_q <= 4'd2;
			in_w_q   <= 13'd64;
			in_h_q   <= 13'd64;
			out_w_q  <= 9'd32;
			out_h_q  <= 13'd32;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POOL_H: pool_h_q <= cfg_data[3:0];
				REG_POOL_W: pool_w_q <= cfg_data[3:0];
				REG_IN_W:   in_w_q   <= cfg_data;
				REG_IN_H:   in_h_q   <= cfg_data;
				REG_OUT_W:  out_w_q  <= cfg_data[8:0];
				REG_OUT_H:  out_h_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	mpau_pos u_pos (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_we (cfg_we),
		.step   (step),
		.pos    (pos),
		.busy   (busy)
	);

	mpau_core #(
		.MAX_OUT_COLS (MAX_OUT_COLS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.accept      (accept),
		.func        (func),
		.value       (value),
		.pos         (pos),
		.hold        (hold),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.out_value   (out_value),
		.arg_row     (arg_row),
		.arg_col     (arg_col),
		.pooled_row  (pooled_row),
		.pooled_col  (pooled_col)
	);

endmodule

`default_nettype wire

@@ rtl/mpau_chk.sv @@
`default_nettype none
`include "max_pool_argmax_unpool_defines.svh"

module mpau_chk
	import mpau_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 cfg_we,
	input wire logic                 in_stall,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic                 result_kind,
	input wire logic signed [VW-1:0] out_value,
	input wire logic [OFF_W-1:0]     arg_row,
	input wire logic [OFF_W-1:0]     arg_col,
	input wire logic [POS_W-1:0]     pooled_row,
	input wire logic [7:0]           pooled_col
);

	logic out_wait, grad_beat, idx_zero;

	assign out_wait  = out_valid && out_stall;
	assign grad_beat = out_valid && (result_kind == KIND_GRAD);
	assign idx_zero  = ({arg_row, arg_col, pooled_row, pooled_col} == '0);

	`MPAU_ASSERT_NEXT(a_out_hold, out_wait, out_valid, "stalled beat dropped")

	`MPAU_ASSERT_NEXT(a_out_stable, out_wait, $stable({result_kind, out_value}), "stalled beat changed")

	`MPAU_ASSERT_NOW(a_grad_fields, grad_beat, idx_zero, "gradient beat with index fields set")

	`MPAU_ASSERT_NEXT(a_cfg_stall, cfg_we, in_stall, "input taken during position rebuild")

endmodule

bind max_pool_argmax_unpool mpau_chk u_chk (.*);

`default_nettype wire
